// ===== src/wpac_pkg.sv =====
// Shared types, thresholds and helpers for the write pressure admission controller.
// No dependencies; used by write_pressure_admission_controller_core.
package wpac_pkg;

  typedef enum logic [1:0] {
    KIND_STAGE  = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    LVL_NORMAL = 2'd0,
    LVL_SOFT   = 2'd1,
    LVL_HARD   = 2'd2
  } level_e;

  localparam int unsigned NumMetrics = 17;

  localparam logic [4:0] M_DISK_BYTES = 5'd0;
  localparam logic [4:0] M_DISK_PCT   = 5'd1;
  localparam logic [4:0] M_ARRIVAL    = 5'd2;
  localparam logic [4:0] M_INTERVAL   = 5'd3;
  localparam logic [4:0] M_ADMITTED   = 5'd4;
  localparam logic [4:0] M_COMPLETED  = 5'd5;
  localparam logic [4:0] M_DEBT       = 5'd6;
  localparam logic [4:0] M_FLUSH_PEND = 5'd7;
  localparam logic [4:0] M_WRITE_STOP = 5'd8;
  localparam logic [4:0] M_BG_ERROR   = 5'd9;
  localparam logic [4:0] M_L0         = 5'd10;
  localparam logic [4:0] M_PEND_COMP  = 5'd11;
  localparam logic [4:0] M_WAL        = 5'd12;
  localparam logic [4:0] M_IMM_COUNT  = 5'd13;
  localparam logic [4:0] M_BACKLOG    = 5'd14;
  localparam logic [4:0] M_IMM_PCT    = 5'd15;
  localparam logic [4:0] M_QDEPTH     = 5'd16;

  localparam logic [63:0] Gib           = 64'd1073741824;
  localparam logic [63:0] SoftPend      = 64'd8 * Gib;
  localparam logic [63:0] HardPend      = 64'd32 * Gib;
  localparam logic [63:0] SoftWal       = 64'd768 * 64'd1048576;
  localparam logic [63:0] HardWal       = Gib;
  localparam logic [63:0] HorizonUs     = 64'd5000000;
  localparam logic [63:0] DiskSoftBytes = 64'd10 * Gib;
  localparam logic [63:0] DiskHardBytes = 64'd4 * Gib;
  localparam logic [63:0] AllOnes       = '1;

  localparam logic [8:0]  CountReset = 9'd128;
  localparam logic [8:0]  CountMin   = 9'd64;
  localparam logic [8:0]  CountMax   = 9'd256;
  localparam logic [8:0]  CountStep  = 9'd64;
  localparam logic [21:0] BytesNormal = 22'd2097152;
  localparam logic [21:0] BytesSoft   = 22'd1048576;
  localparam logic [21:0] BytesHard   = 22'd524288;
  localparam logic [7:0]  WindowOpen  = 8'd200;
  localparam logic [7:0]  WindowShut  = 8'd0;

  // exponential average, alpha 1/8; an empty average takes the sample outright
  function automatic logic [63:0] avg_update(input logic [63:0] cur, input logic [63:0] s);
    logic [63:0] res;
    if (cur == 64'd0) begin
      res = s;
    end else begin
      res = cur - (cur >> 3) + (s >> 3);
    end
    return res;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[64] ? AllOnes : sum[63:0];
  endfunction

endpackage

// ===== src/write_pressure_admission_controller_core.sv =====
// Write pressure admission controller: metric staging, pressure level tracking
// and admission decisions. Depends on wpac_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one item per transfer:
//    a stage item writes one of seventeen staged metrics, a commit item
//    evaluates the staged sample, a query item asks for admission.
//  - Output channel (out_valid_o / out_stall_i) carries one result per commit
//    or query transfer; stage items and kind 3 give none.
//  - Timing: a transfer lands in an input register, is evaluated from there
//    once it may advance, and its result is loaded into the output register,
//    which drives out_valid_o.
//  - Throughput: one item per cycle unless stalled. Evaluation is a single pass of
//    logic between the input register and the result register; its longest
//    path is the average update feeding the debt projection and thresholds.
//  - Stall: while the output register holds a result and out_stall_i is high,
//    the item in the input register waits and in_stall_o goes high; an item
//    with no result waits too, keeping order simple.
//  - Reset: metrics, averages and counters clear, level is normal, targets are
//    128 items, 2 MiB and 200 us; both channels come up empty.
module write_pressure_admission_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [4:0]  field_select_i,
  input  logic [63:0] field_value_i,
  input  logic [31:0] request_count_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] deadline_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  pressure_level_o,
  output logic        admit_o,
  output logic [8:0]  batch_count_o,
  output logic [21:0] batch_bytes_o,
  output logic [7:0]  window_us_o,
  output logic [63:0] projected_debt_o
);

  // ---------------------------------------------------------------- input register
  logic        in_valid_q;
  logic [1:0]  kind_q;
  logic [4:0]  sel_q;
  logic [63:0] value_q;
  logic [31:0] rc_q, rb_q, dl_q;
  logic        out_valid_q;

  logic advance;
  logic in_take;

  // the input register advances when the output register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  logic stage_fire, commit_fire, query_fire;
  assign stage_fire  = advance && (kind_q == wpac_pkg::KIND_STAGE);
  assign commit_fire = advance && (kind_q == wpac_pkg::KIND_COMMIT);
  assign query_fire  = advance && (kind_q == wpac_pkg::KIND_QUERY);

  // ---------------------------------------------------------------- state
  logic [63:0]      m_q [wpac_pkg::NumMetrics];
  wpac_pkg::level_e level_q, level_d;
  logic [1:0]       rec_q, rec_d;
  logic [7:0]       dcount_q, dcount_d;
  logic [63:0]      dtime_q, dtime_d;
  logic [63:0]      adm_q, adm_d;
  logic [63:0]      bg_q, bg_d;
  logic [63:0]      debt_q, debt_d;
  logic [2:0]       busy_q, busy_d;
  logic [8:0]       count_q, count_d;
  logic [21:0]      bytes_q, bytes_d;
  logic [7:0]       window_q, window_d;

  // ---------------------------------------------------------------- commit evaluation
  logic        valid_ivl, disk_ok;
  logic [63:0] observed, gap, span;
  logic [66:0] gap5;
  logic        healthy, deficit;
  logic        disk_soft, disk_hard, disk_rec_soft, disk_rec_hard;
  logic        hard, soft_cond, busy;
  logic        hard_hold, soft_hold;
  logic [1:0]  rec_inc;
  logic [2:0]  busy_inc;
  logic [9:0]  count_up;

  always_comb begin
    valid_ivl = m_q[wpac_pkg::M_INTERVAL] != 64'd0;
    disk_ok   = m_q[wpac_pkg::M_DISK_BYTES] != wpac_pkg::AllOnes;

    adm_d = valid_ivl ? wpac_pkg::avg_update(adm_q, m_q[wpac_pkg::M_ADMITTED]) : adm_q;
    bg_d  = valid_ivl ? wpac_pkg::avg_update(bg_q, m_q[wpac_pkg::M_COMPLETED]) : bg_q;

    observed = (m_q[wpac_pkg::M_DEBT] > m_q[wpac_pkg::M_FLUSH_PEND]) ?
               m_q[wpac_pkg::M_DEBT] : m_q[wpac_pkg::M_FLUSH_PEND];

    // debt projected over a five second horizon, saturating
    gap  = adm_d - bg_d;
    gap5 = {3'b000, gap} + {1'b0, gap, 2'b00};
    span = (gap5[66:64] != 3'b000) ? wpac_pkg::AllOnes : gap5[63:0];
    debt_d = (adm_d <= bg_d) ? observed : wpac_pkg::sat_add(observed, span);

    healthy = !valid_ivl || (bg_d >= adm_d);
    deficit = valid_ivl && (adm_d > bg_d);

    if (deficit) begin
      dcount_d = (dcount_q == 8'hFF) ? dcount_q : dcount_q + 8'd1;
      dtime_d  = wpac_pkg::sat_add(dtime_q, m_q[wpac_pkg::M_INTERVAL]);
    end else begin
      dcount_d = 8'd0;
      dtime_d  = 64'd0;
    end

    disk_soft = disk_ok && (m_q[wpac_pkg::M_DISK_BYTES] < wpac_pkg::DiskSoftBytes ||
                            m_q[wpac_pkg::M_DISK_PCT] < 64'd10);
    disk_hard = disk_ok && (m_q[wpac_pkg::M_DISK_BYTES] < wpac_pkg::DiskHardBytes ||
                            m_q[wpac_pkg::M_DISK_PCT] < 64'd5);
    disk_rec_soft = !disk_ok || (m_q[wpac_pkg::M_DISK_BYTES] >= wpac_pkg::DiskSoftBytes &&
                                 m_q[wpac_pkg::M_DISK_PCT] >= 64'd10);
    disk_rec_hard = !disk_ok || (m_q[wpac_pkg::M_DISK_BYTES] >= wpac_pkg::DiskHardBytes &&
                                 m_q[wpac_pkg::M_DISK_PCT] >= 64'd5);

    hard = m_q[wpac_pkg::M_WRITE_STOP] != 64'd0 || m_q[wpac_pkg::M_BG_ERROR] != 64'd0 ||
           disk_hard || m_q[wpac_pkg::M_L0] >= 64'd24 ||
           m_q[wpac_pkg::M_PEND_COMP] >= wpac_pkg::HardPend ||
           m_q[wpac_pkg::M_WAL] >= wpac_pkg::HardWal ||
           m_q[wpac_pkg::M_IMM_COUNT] >= 64'd4 || m_q[wpac_pkg::M_BACKLOG] >= 64'd2 ||
           m_q[wpac_pkg::M_IMM_PCT] >= 64'd90 ||
           (dtime_d >= wpac_pkg::HorizonUs && observed >= wpac_pkg::SoftPend &&
            debt_d >= wpac_pkg::HardPend);
    soft_cond = disk_soft || m_q[wpac_pkg::M_L0] >= 64'd16 ||
                m_q[wpac_pkg::M_PEND_COMP] >= wpac_pkg::SoftPend ||
                m_q[wpac_pkg::M_WAL] >= wpac_pkg::SoftWal ||
                m_q[wpac_pkg::M_IMM_COUNT] >= 64'd2 || m_q[wpac_pkg::M_BACKLOG] >= 64'd1 ||
                m_q[wpac_pkg::M_IMM_PCT] >= 64'd75 ||
                (dcount_d >= 8'd3 && debt_d >= wpac_pkg::SoftPend);

    // hysteresis: conditions that keep the current level held
    hard_hold = hard || !healthy || !disk_rec_hard || m_q[wpac_pkg::M_L0] >= 64'd16 ||
                m_q[wpac_pkg::M_PEND_COMP] >= wpac_pkg::SoftPend ||
                m_q[wpac_pkg::M_WAL] >= wpac_pkg::SoftWal ||
                m_q[wpac_pkg::M_IMM_COUNT] >= 64'd2 || m_q[wpac_pkg::M_BACKLOG] >= 64'd1 ||
                m_q[wpac_pkg::M_IMM_PCT] >= 64'd70;
    soft_hold = soft_cond || !healthy || !disk_rec_soft || m_q[wpac_pkg::M_L0] > 64'd12 ||
                m_q[wpac_pkg::M_PEND_COMP] >= (wpac_pkg::SoftPend >> 1) ||
                m_q[wpac_pkg::M_WAL] >= wpac_pkg::SoftWal ||
                m_q[wpac_pkg::M_IMM_COUNT] != 64'd0 || m_q[wpac_pkg::M_BACKLOG] != 64'd0 ||
                m_q[wpac_pkg::M_IMM_PCT] != 64'd0;

    rec_inc = rec_q + 2'd1;
    level_d = level_q;
    rec_d   = rec_q;
    unique case (level_q)
      wpac_pkg::LVL_HARD: begin
        if (hard_hold) begin
          rec_d = 2'd0;
        end else if (rec_inc == 2'd3) begin
          level_d = soft_cond ? wpac_pkg::LVL_SOFT : wpac_pkg::LVL_NORMAL;
          rec_d   = 2'd0;
        end else begin
          rec_d = rec_inc;
        end
      end
      wpac_pkg::LVL_SOFT: begin
        if (hard) begin
          level_d = wpac_pkg::LVL_HARD;
          rec_d   = 2'd0;
        end else if (soft_hold) begin
          rec_d = 2'd0;
        end else if (rec_inc == 2'd3) begin
          level_d = wpac_pkg::LVL_NORMAL;
          rec_d   = 2'd0;
        end else begin
          rec_d = rec_inc;
        end
      end
      default: begin
        level_d = hard ? wpac_pkg::LVL_HARD :
                  (soft_cond ? wpac_pkg::LVL_SOFT : wpac_pkg::LVL_NORMAL);
        rec_d   = 2'd0;
      end
    endcase

    // batch targets follow the new level
    busy     = m_q[wpac_pkg::M_ARRIVAL] >= 64'd256 || m_q[wpac_pkg::M_QDEPTH] >= 64'd64;
    busy_inc = busy_q + 3'd1;
    count_up = {1'b0, count_q} + {1'b0, wpac_pkg::CountStep};
    count_d  = count_q;
    busy_d   = busy_q;
    if (level_d == wpac_pkg::LVL_NORMAL && busy) begin
      if (busy_inc >= 3'd4) begin
        count_d = (count_up > {1'b0, wpac_pkg::CountMax}) ? wpac_pkg::CountMax : count_up[8:0];
        busy_d  = 3'd0;
      end else begin
        busy_d = busy_inc;
      end
    end else begin
      busy_d = 3'd0;
      if (level_d == wpac_pkg::LVL_NORMAL) begin
        count_d = wpac_pkg::CountReset;
      end
    end

    unique case (level_d)
      wpac_pkg::LVL_SOFT: begin
        count_d  = wpac_pkg::CountMin;
        bytes_d  = wpac_pkg::BytesSoft;
        window_d = wpac_pkg::WindowOpen;
      end
      wpac_pkg::LVL_HARD: begin
        count_d  = wpac_pkg::CountMin;
        bytes_d  = wpac_pkg::BytesHard;
        window_d = wpac_pkg::WindowShut;
      end
      default: begin
        bytes_d  = wpac_pkg::BytesNormal;
        window_d = wpac_pkg::WindowOpen;
      end
    endcase
  end

  // ---------------------------------------------------------------- admission decision
  logic admit_q_d;
  always_comb begin
    admit_q_d = level_q != wpac_pkg::LVL_HARD;
    if (level_q == wpac_pkg::LVL_SOFT && dl_q == 32'd0 && rc_q != 32'd0) begin
      admit_q_d = 1'b0;
    end
    if (rc_q >= {23'd0, count_q} || rb_q >= {10'd0, bytes_q}) begin
      admit_q_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  logic [1:0]  lvl_o_q;
  logic        admit_o_q;
  logic [8:0]  cnt_o_q;
  logic [21:0] bytes_o_q;
  logic [7:0]  win_o_q;
  logic [63:0] debt_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < wpac_pkg::NumMetrics; i++) begin
        m_q[i] <= 64'd0;
      end
      level_q  <= wpac_pkg::LVL_NORMAL;
      rec_q    <= 2'd0;
      dcount_q <= 8'd0;
      dtime_q  <= 64'd0;
      adm_q    <= 64'd0;
      bg_q     <= 64'd0;
      debt_q   <= 64'd0;
      busy_q   <= 3'd0;
      count_q  <= wpac_pkg::CountReset;
      bytes_q  <= wpac_pkg::BytesNormal;
      window_q <= wpac_pkg::WindowOpen;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (stage_fire && sel_q < 5'(wpac_pkg::NumMetrics)) begin
        m_q[sel_q] <= value_q;
      end

      if (commit_fire) begin
        level_q  <= level_d;
        rec_q    <= rec_d;
        dcount_q <= dcount_d;
        dtime_q  <= dtime_d;
        adm_q    <= adm_d;
        bg_q     <= bg_d;
        debt_q   <= debt_d;
        busy_q   <= busy_d;
        count_q  <= count_d;
        bytes_q  <= bytes_d;
        window_q <= window_d;
      end

      if (commit_fire || query_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q  <= kind_i;
      sel_q   <= field_select_i;
      value_q <= field_value_i;
      rc_q    <= request_count_i;
      rb_q    <= request_bytes_i;
      dl_q    <= deadline_us_i;
    end
    if (commit_fire) begin
      lvl_o_q   <= level_d;
      admit_o_q <= 1'b0;
      cnt_o_q   <= count_d;
      bytes_o_q <= bytes_d;
      win_o_q   <= window_d;
      debt_o_q  <= debt_d;
    end else if (query_fire) begin
      lvl_o_q   <= level_q;
      admit_o_q <= admit_q_d;
      cnt_o_q   <= count_q;
      bytes_o_q <= bytes_q;
      win_o_q   <= window_q;
      debt_o_q  <= debt_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pressure_level_o = lvl_o_q;
  assign admit_o          = admit_o_q;
  assign batch_count_o    = cnt_o_q;
  assign batch_bytes_o    = bytes_o_q;
  assign window_us_o      = win_o_q;
  assign projected_debt_o = debt_o_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for write_pressure_admission_controller_core.
// Drives staged metrics, commits and admission queries with random idling on
// both channels and checks every result against an in-bench predictor; needs wpac_pkg.
module testbench;

  // Thresholds held locally so that the predictor stands apart from the RTL.
  localparam logic [63:0] ONE_GIB    = 64'd1 << 30;
  localparam logic [63:0] PEND_SOFT  = 64'd8 * ONE_GIB;
  localparam logic [63:0] PEND_HARD  = 64'd32 * ONE_GIB;
  localparam logic [63:0] WAL_SOFT   = 64'd768 * 64'd1048576;
  localparam logic [63:0] WAL_HARD   = ONE_GIB;
  localparam logic [63:0] HORIZON    = 64'd5000000;
  localparam logic [63:0] DISK_SOFT  = 64'd10 * ONE_GIB;
  localparam logic [63:0] DISK_HARD  = 64'd4 * ONE_GIB;
  localparam logic [63:0] ALL_ONES64 = {64{1'b1}};

  localparam int RANDOM_ITEMS = 1700;
  localparam int LONG_RUN     = 280;      // enough commits to pin the deficit counter
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    wpac_pkg::kind_e kind;
    logic [4:0]      sel;
    logic [63:0]     value;
    logic [31:0]     rc;
    logic [31:0]     rb;
    logic [31:0]     dl;
  } work_item_t;

  typedef struct {
    logic [1:0]  lvl_code;
    logic        admit;
    logic [8:0]  cnt;
    logic [21:0] byt;
    logic [7:0]  win;
    logic [63:0] debt;
  } result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = 2'd0;
  logic [4:0]  field_select_i = 5'd0;
  logic [63:0] field_value_i = 64'd0;
  logic [31:0] request_count_i = 32'd0;
  logic [31:0] request_bytes_i = 32'd0;
  logic [31:0] deadline_us_i = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  pressure_level_o;
  logic        admit_o;
  logic [8:0]  batch_count_o;
  logic [21:0] batch_bytes_o;
  logic [7:0]  window_us_o;
  logic [63:0] projected_debt_o;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  write_pressure_admission_controller_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .field_select_i   (field_select_i),
    .field_value_i    (field_value_i),
    .request_count_i  (request_count_i),
    .request_bytes_i  (request_bytes_i),
    .deadline_us_i    (deadline_us_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pressure_level_o (pressure_level_o),
    .admit_o          (admit_o),
    .batch_count_o    (batch_count_o),
    .batch_bytes_o    (batch_bytes_o),
    .window_us_o      (window_us_o),
    .projected_debt_o (projected_debt_o)
  );

  // ---------------------------------------------------------------------------
  // Predictor state, mirrors the controller after reset
  // ---------------------------------------------------------------------------
  logic [63:0]      staged [wpac_pkg::NumMetrics];
  wpac_pkg::level_e lvl = wpac_pkg::LVL_NORMAL;
  int unsigned      recovery = 0;
  int unsigned      deficit_runs = 0;
  logic [63:0]      deficit_us = 64'd0;
  logic [63:0]      admitted_ema = 64'd0;
  logic [63:0]      background_ema = 64'd0;
  logic [63:0]      debt_est = 64'd0;
  int unsigned      busy_runs = 0;
  int unsigned      cnt_tgt = 128;
  logic [21:0]      byt_tgt = 22'd2097152;
  logic [7:0]       win_tgt = 8'd200;

  work_item_t pending_items [$];
  result_t    results_due [$];
  int         errors = 0;
  int         useful_items = 0;
  logic       draining = 1'b0;

  function automatic logic [63:0] ema_next(logic [63:0] cur, logic [63:0] s);
    if (cur == 64'd0) return s;
    return cur - cur / 8 + s / 8;
  endfunction

  function automatic logic [63:0] add_clamp(logic [63:0] a, logic [63:0] b);
    return (a > ALL_ONES64 - b) ? ALL_ONES64 : a + b;
  endfunction

  function automatic result_t current_result(logic admit);
    result_t r;
    r.lvl_code = lvl;
    r.admit    = admit;
    r.cnt      = cnt_tgt[8:0];
    r.byt      = byt_tgt;
    r.win      = win_tgt;
    r.debt     = debt_est;
    return r;
  endfunction

  // Commit: averages, debt projection, deficit run, level and batch targets.
  task automatic evaluate_sample();
    logic [63:0] observed;
    logic [63:0] gap;
    logic [66:0] span;
    logic disk_ok, iv_ok, healthy, short_fall, hard, soft_cond, busy;
    logic dsk_soft, dsk_hard, dsk_rec_soft, dsk_rec_hard, hard_hold, soft_hold;
    logic [63:0] disk_b, disk_p, l0, pend, wal, imm_n, backlog, imm_p;
    disk_b  = staged[wpac_pkg::M_DISK_BYTES];
    disk_p  = staged[wpac_pkg::M_DISK_PCT];
    l0      = staged[wpac_pkg::M_L0];
    pend    = staged[wpac_pkg::M_PEND_COMP];
    wal     = staged[wpac_pkg::M_WAL];
    imm_n   = staged[wpac_pkg::M_IMM_COUNT];
    backlog = staged[wpac_pkg::M_BACKLOG];
    imm_p   = staged[wpac_pkg::M_IMM_PCT];
    disk_ok = disk_b != ALL_ONES64;
    iv_ok = staged[wpac_pkg::M_INTERVAL] != 64'd0;
    if (iv_ok) begin
      admitted_ema = ema_next(admitted_ema, staged[wpac_pkg::M_ADMITTED]);
      background_ema = ema_next(background_ema, staged[wpac_pkg::M_COMPLETED]);
    end
    observed = (staged[wpac_pkg::M_DEBT] > staged[wpac_pkg::M_FLUSH_PEND]) ?
               staged[wpac_pkg::M_DEBT] : staged[wpac_pkg::M_FLUSH_PEND];
    if (admitted_ema > background_ema) begin
      gap = admitted_ema - background_ema;
      span = {3'b000, gap} * 67'd5;
      debt_est = add_clamp(observed, (span[66:64] != 3'b000) ? ALL_ONES64 : span[63:0]);
    end else begin
      debt_est = observed;
    end

    healthy = !iv_ok || (background_ema >= admitted_ema);
    short_fall = iv_ok && (admitted_ema > background_ema);
    if (short_fall) begin
      if (deficit_runs < 255) deficit_runs++;
      deficit_us = add_clamp(deficit_us, staged[wpac_pkg::M_INTERVAL]);
    end else begin
      deficit_runs = 0;
      deficit_us = 64'd0;
    end

    dsk_soft = disk_ok && (disk_b < DISK_SOFT || disk_p < 64'd10);
    dsk_hard = disk_ok && (disk_b < DISK_HARD || disk_p < 64'd5);
    dsk_rec_soft = !disk_ok || (disk_b >= DISK_SOFT && disk_p >= 64'd10);
    dsk_rec_hard = !disk_ok || (disk_b >= DISK_HARD && disk_p >= 64'd5);

    hard = staged[wpac_pkg::M_WRITE_STOP] != 64'd0 ||
           staged[wpac_pkg::M_BG_ERROR] != 64'd0 || dsk_hard ||
           l0 >= 64'd24 || pend >= PEND_HARD || wal >= WAL_HARD || imm_n >= 64'd4 ||
           backlog >= 64'd2 || imm_p >= 64'd90 ||
           (deficit_us >= HORIZON && observed >= PEND_SOFT && debt_est >= PEND_HARD);
    soft_cond = dsk_soft || l0 >= 64'd16 || pend >= PEND_SOFT || wal >= WAL_SOFT ||
                imm_n >= 64'd2 || backlog >= 64'd1 || imm_p >= 64'd75 ||
                (deficit_runs >= 3 && debt_est >= PEND_SOFT);

    // hysteresis: leaving a level needs metrics well clear of its entry point
    hard_hold = hard || !healthy || !dsk_rec_hard || l0 >= 64'd16 ||
                pend >= PEND_SOFT || wal >= WAL_SOFT ||
                imm_n >= 64'd2 || backlog >= 64'd1 || imm_p >= 64'd70;
    soft_hold = soft_cond || !healthy || !dsk_rec_soft || l0 > 64'd12 ||
                pend >= PEND_SOFT / 2 || wal >= WAL_SOFT ||
                imm_n != 64'd0 || backlog != 64'd0 || imm_p != 64'd0;

    case (lvl)
      wpac_pkg::LVL_HARD: begin
        if (hard_hold) begin
          recovery = 0;
        end else begin
          recovery++;
          if (recovery >= 3) begin
            if (soft_cond) lvl = wpac_pkg::LVL_SOFT;
            else lvl = wpac_pkg::LVL_NORMAL;
            recovery = 0;
          end
        end
      end
      wpac_pkg::LVL_SOFT: begin
        if (hard) begin
          lvl = wpac_pkg::LVL_HARD;
          recovery = 0;
        end else if (soft_hold) begin
          recovery = 0;
        end else begin
          recovery++;
          if (recovery >= 3) begin
            lvl = wpac_pkg::LVL_NORMAL;
            recovery = 0;
          end
        end
      end
      default: begin
        if (hard) lvl = wpac_pkg::LVL_HARD;
        else if (soft_cond) lvl = wpac_pkg::LVL_SOFT;
        else lvl = wpac_pkg::LVL_NORMAL;
        recovery = 0;
      end
    endcase

    // sustained load in the normal level widens the batch count
    busy = staged[wpac_pkg::M_ARRIVAL] >= 64'd256 || staged[wpac_pkg::M_QDEPTH] >= 64'd64;
    if (lvl == wpac_pkg::LVL_NORMAL && busy) begin
      busy_runs++;
      if (busy_runs >= 4) begin
        cnt_tgt = (cnt_tgt + 64 > 256) ? 256 : cnt_tgt + 64;
        busy_runs = 0;
      end
    end else begin
      busy_runs = 0;
      if (lvl == wpac_pkg::LVL_NORMAL) cnt_tgt = 128;
    end
    case (lvl)
      wpac_pkg::LVL_SOFT: begin
        cnt_tgt = 64;
        byt_tgt = 22'd1048576;
        win_tgt = 8'd200;
      end
      wpac_pkg::LVL_HARD: begin
        cnt_tgt = 64;
        byt_tgt = 22'd524288;
        win_tgt = 8'd0;
      end
      default: begin
        byt_tgt = 22'd2097152;
        win_tgt = 8'd200;
      end
    endcase
  endtask

  task automatic advance_controller(work_item_t it);
    logic admit;
    case (it.kind)
      wpac_pkg::KIND_STAGE: begin
        if (it.sel < 5'(wpac_pkg::NumMetrics)) staged[it.sel] = it.value;
      end
      wpac_pkg::KIND_COMMIT: begin
        evaluate_sample();
        results_due.push_back(current_result(1'b0));
      end
      wpac_pkg::KIND_QUERY: begin
        admit = (lvl != wpac_pkg::LVL_HARD);
        if (lvl == wpac_pkg::LVL_SOFT && it.dl == 32'd0 && it.rc != 32'd0) admit = 1'b0;
        if (it.rc >= cnt_tgt || it.rb >= {10'd0, byt_tgt}) admit = 1'b0;
        results_due.push_back(current_result(admit));
      end
      default: ;
    endcase
  endtask

  task automatic check_result(result_t got, result_t want);
    if (got.lvl_code !== want.lvl_code) begin
      $error("pressure_level: expected %0d, got %0d", want.lvl_code, got.lvl_code);
      errors++;
    end
    if (got.admit !== want.admit) begin
      $error("admit: expected %0d, got %0d", want.admit, got.admit);
      errors++;
    end
    if (got.cnt !== want.cnt) begin
      $error("batch_count: expected %0d, got %0d", want.cnt, got.cnt);
      errors++;
    end
    if (got.byt !== want.byt) begin
      $error("batch_bytes: expected %0d, got %0d", want.byt, got.byt);
      errors++;
    end
    if (got.win !== want.win) begin
      $error("window_us: expected %0d, got %0d", want.win, got.win);
      errors++;
    end
    if (got.debt !== want.debt) begin
      $error("projected_debt: expected %0h, got %0h", want.debt, got.debt);
      errors++;
    end
  endtask

  // Idle length: mostly none or short, now and then long, with calm stretches.
  function automatic int idle_span(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(wpac_pkg::kind_e k, logic [4:0] sel, logic [63:0] val,
                            logic [31:0] rc, logic [31:0] rb, logic [31:0] dl);
    work_item_t it;
    it.kind  = k;
    it.sel   = sel;
    it.value = val;
    it.rc    = rc;
    it.rb    = rb;
    it.dl    = dl;
    pending_items.push_back(it);
    if (!(k == wpac_pkg::KIND_NONE ||
          (k == wpac_pkg::KIND_STAGE && sel >= 5'(wpac_pkg::NumMetrics)))) begin
      useful_items++;
    end
  endtask

  // request fields ride along on stage and commit transfers as junk
  task automatic put_stage(logic [4:0] sel, logic [63:0] val);
    queue_item(wpac_pkg::KIND_STAGE, sel, val, $urandom, $urandom, $urandom);
  endtask

  task automatic put_commit();
    queue_item(wpac_pkg::KIND_COMMIT, 5'($urandom), {$urandom, $urandom},
               $urandom, $urandom, $urandom);
  endtask

  task automatic put_query(logic [31:0] rc, logic [31:0] rb, logic [31:0] dl);
    queue_item(wpac_pkg::KIND_QUERY, 5'($urandom), {$urandom, $urandom}, rc, rb, dl);
  endtask

  // Request sizes cluster around the batch targets.
  function automatic logic [31:0] request_size(bit bytes_side);
    logic [31:0] base;
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return 32'd0;
    if (k == 1) return 32'hFFFF_FFFF;
    if (k == 2) return $urandom;
    if (bytes_side) begin
      case ($urandom_range(0, 2))
        0: base = 32'd524288;
        1: base = 32'd1048576;
        default: base = 32'd2097152;
      endcase
    end else begin
      base = 32'd64 * $urandom_range(1, 4);
    end
    return base + $urandom_range(0, 2) - 32'd1;
  endfunction

  function automatic logic [63:0] threshold_of(logic [4:0] sel, int unsigned k);
    logic [63:0] t;
    t = 64'd0;
    case (sel)
      wpac_pkg::M_DISK_BYTES: t = (k == 0) ? DISK_HARD : (k == 1) ? DISK_SOFT : ALL_ONES64;
      wpac_pkg::M_DISK_PCT:   t = (k == 0) ? 64'd5 : 64'd10;
      wpac_pkg::M_ARRIVAL:    t = 64'd256;
      wpac_pkg::M_INTERVAL:   t = (k == 0) ? 64'd0 : (k == 1) ? HORIZON : ALL_ONES64;
      wpac_pkg::M_ADMITTED, wpac_pkg::M_COMPLETED: t = 64'd1 << $urandom_range(0, 63);
      wpac_pkg::M_DEBT, wpac_pkg::M_FLUSH_PEND:
        t = (k == 0) ? PEND_SOFT : (k == 1) ? PEND_HARD : PEND_SOFT / 2;
      wpac_pkg::M_WRITE_STOP, wpac_pkg::M_BG_ERROR: t = 64'd0;
      wpac_pkg::M_L0:         t = (k == 0) ? 64'd12 : (k == 1) ? 64'd16 : 64'd24;
      wpac_pkg::M_PEND_COMP:  t = (k == 0) ? PEND_SOFT / 2 : (k == 1) ? PEND_SOFT : PEND_HARD;
      wpac_pkg::M_WAL:        t = (k == 0) ? WAL_SOFT : WAL_HARD;
      wpac_pkg::M_IMM_COUNT:  t = (k == 0) ? 64'd1 : (k == 1) ? 64'd2 : 64'd4;
      wpac_pkg::M_BACKLOG:    t = (k == 0) ? 64'd1 : 64'd2;
      wpac_pkg::M_IMM_PCT:    t = (k == 0) ? 64'd70 : (k == 1) ? 64'd75 : 64'd90;
      wpac_pkg::M_QDEPTH:     t = 64'd64;
      default:                t = 64'd0;
    endcase
    return t;
  endfunction

  // Stress value: a threshold give or take one, a small value, or something wide.
  function automatic logic [63:0] pick_value(logic [4:0] sel);
    logic [63:0] t;
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return {$urandom, $urandom};
    if (r == 2) return 64'($urandom_range(0, 40));
    t = threshold_of(sel, $urandom_range(0, 2));
    case ($urandom_range(0, 2))
      0: return t - 64'd1;
      1: return t;
      default: return t + 64'd1;
    endcase
  endfunction

  // Values that keep every metric clear of the recovery thresholds.
  function automatic logic [63:0] benign_value(logic [4:0] sel);
    logic [63:0] v;
    v = 64'd0;
    case (sel)
      wpac_pkg::M_DISK_BYTES:
        v = ($urandom_range(0, 3) == 0) ? ALL_ONES64 : DISK_SOFT + 64'($urandom);
      wpac_pkg::M_DISK_PCT: v = 64'($urandom_range(10, 100));
      wpac_pkg::M_ARRIVAL:
        v = ($urandom_range(0, 3) != 0) ? 64'd256 + 64'($urandom_range(0, 1000))
                                        : 64'($urandom_range(0, 255));
      wpac_pkg::M_INTERVAL:
        v = ($urandom_range(0, 9) < 6) ? 64'd0 : 64'($urandom_range(1, 1000000));
      wpac_pkg::M_ADMITTED:  v = 64'($urandom_range(0, 1000));
      wpac_pkg::M_COMPLETED: v = 64'd1000 + 64'($urandom);
      wpac_pkg::M_DEBT, wpac_pkg::M_FLUSH_PEND, wpac_pkg::M_PEND_COMP: v = 64'($urandom);
      wpac_pkg::M_L0:        v = 64'($urandom_range(0, 12));
      wpac_pkg::M_WAL:       v = 64'($urandom_range(0, 700000000));
      wpac_pkg::M_QDEPTH:
        v = ($urandom_range(0, 3) != 0) ? 64'd64 + 64'($urandom_range(0, 500))
                                        : 64'($urandom_range(0, 63));
      default:               v = 64'd0;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, runs the predictor on each input transfer
  // ---------------------------------------------------------------------------
  work_item_t cur_item;
  int         gap_left = 0;
  int         drv_calm = 0;

  always @(posedge clk_i) begin : item_driver
    bit holding;
    if (rst_ni) begin
      holding = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        advance_controller(cur_item);
        holding = 1'b0;
        gap_left = idle_span(drv_calm);
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          holding = 1'b1;
          kind_i          <= cur_item.kind;
          field_select_i  <= cur_item.sel;
          field_value_i   <= cur_item.value;
          request_count_i <= cur_item.rc;
          request_bytes_i <= cur_item.rb;
          deadline_us_i   <= cur_item.dl;
        end
      end
      // valid only falls when nothing is waiting, so it never toggles in one step
      in_valid_i <= holding;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each output transfer, applies random back-pressure
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int mon_calm = 0;

  always @(posedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.lvl_code = pressure_level_o;
        got.admit    = admit_o;
        got.cnt      = batch_count_o;
        got.byt      = batch_bytes_o;
        got.win      = window_us_o;
        got.debt     = projected_debt_o;
        if (results_due.size() == 0) begin
          $error("result transfer with no result expected");
          errors++;
        end else begin
          check_result(got, results_due.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = idle_span(mon_calm);
      end
      out_stall_i <= (stall_left > 0) && !draining;
    end
  end

  // Watchdog against a hung handshake or a lost result.
  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [16:0] dirty;
    logic [4:0]  sel;
    int          start, roll, n;
    bit          long_run_done;

    for (int i = 0; i < wpac_pkg::NumMetrics; i++) staged[i] = 64'd0;

    // Directed part.
    put_query(32'd0, 32'd0, 32'd0);                 // admit straight after reset
    queue_item(wpac_pkg::KIND_NONE, 5'd31, ALL_ONES64,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_stage(5'd17, ALL_ONES64);                   // metric numbers past the end
    put_stage(5'd31, ALL_ONES64);
    put_commit();                                   // all-zero sample: disk empty, hard
    put_query(32'd1, 32'd0, 32'd0);
    put_stage(wpac_pkg::M_DISK_BYTES, ALL_ONES64);  // disk signal missing
    repeat (3) put_commit();                        // three clean samples leave hard
    put_stage(wpac_pkg::M_INTERVAL, 64'd1000);
    put_stage(wpac_pkg::M_ADMITTED, 64'd4000);
    put_stage(wpac_pkg::M_COMPLETED, 64'd1000);
    put_commit();                                   // empty averages take the sample
    put_stage(wpac_pkg::M_INTERVAL, ALL_ONES64);
    repeat (2) put_commit();                        // deficit time clamps at all-ones
    put_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_stage(wpac_pkg::M_QDEPTH, ALL_ONES64);
    put_stage(wpac_pkg::M_DISK_BYTES, 64'd0);
    put_stage(wpac_pkg::M_INTERVAL, 64'd0);         // zero interval keeps averages
    put_commit();
    put_query(32'd0, 32'd0, 32'hFFFF_FFFF);

    // Random part: episodes of clean samples, stressed samples and deficit runs.
    dirty = '1;
    long_run_done = 1'b0;
    start = useful_items;
    while (useful_items - start < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_item(wpac_pkg::KIND_NONE, 5'($urandom), {$urandom, $urandom},
                     $urandom, $urandom, $urandom);
        end else begin
          put_stage(5'($urandom_range(17, 31)), {$urandom, $urandom});
        end
      end else if (roll < 38) begin
        for (int s = 0; s < wpac_pkg::NumMetrics; s++) begin
          sel = 5'(s);
          if (dirty[s] || sel == wpac_pkg::M_INTERVAL || sel == wpac_pkg::M_ADMITTED ||
              sel == wpac_pkg::M_COMPLETED || $urandom_range(0, 5) == 0) begin
            put_stage(sel, benign_value(sel));
          end
        end
        dirty = '0;
        repeat ($urandom_range(1, 5)) put_commit();
        repeat ($urandom_range(0, 2)) put_query(request_size(0), request_size(1),
            ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom);
      end else if (roll < 85) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          sel = 5'($urandom_range(0, wpac_pkg::NumMetrics - 1));
          put_stage(sel, pick_value(sel));
          dirty[sel] = 1'b1;
        end
        put_commit();
        repeat ($urandom_range(0, 2)) put_query(request_size(0), request_size(1),
            ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom);
      end else if (roll < 95) begin
        // admitted rate well above the background rate
        put_stage(wpac_pkg::M_INTERVAL, 64'($urandom_range(1, 2000000)));
        put_stage(wpac_pkg::M_ADMITTED, 64'd1 << $urandom_range(30, 62));
        put_stage(wpac_pkg::M_COMPLETED, 64'($urandom_range(0, 1000)));
        if ($urandom_range(0, 1) == 0) begin
          put_stage(wpac_pkg::M_DEBT, pick_value(wpac_pkg::M_DEBT));
        end
        dirty[wpac_pkg::M_INTERVAL] = 1'b1;
        dirty[wpac_pkg::M_ADMITTED] = 1'b1;
        dirty[wpac_pkg::M_COMPLETED] = 1'b1;
        dirty[wpac_pkg::M_DEBT] = 1'b1;
        if (!long_run_done && useful_items - start > 700) begin
          repeat (LONG_RUN) put_commit();           // deficit counter saturates
          long_run_done = 1'b1;
        end else begin
          repeat ($urandom_range(3, 12)) put_commit();
        end
        put_query(request_size(0), request_size(1), 32'd0);
      end else begin
        repeat ($urandom_range(1, 4)) put_query(request_size(0), request_size(1),
            ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i || results_due.size() != 0) begin
      @(negedge clk_i);
    end
    // stop stalling so that any stray result shows up in the tail
    draining = 1'b1;
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
